// File: rtl/core/versioned_text_buffer_with_undo_unit_macros.svh
// assertion macros for the versioned text buffer with undo
// no dependencies; included by files that carry concurrent checks
`ifndef VERSIONED_TEXT_BUFFER_WITH_UNDO_UNIT_MACROS_SVH
`define VERSIONED_TEXT_BUFFER_WITH_UNDO_UNIT_MACROS_SVH

// same-cycle implication
`define VTB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VTB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/vtb_pkg.sv
// shared constants, codes and types for the versioned text buffer
// no dependencies; imported by vtb_tree_walk and the top level
package vtb_pkg;

  localparam int MAX_OPS    = 1024;
  localparam int POOL_DEPTH = 16384;

  localparam int VER_W   = $clog2(MAX_OPS + 1);
  localparam int NODE_AW = $clog2(POOL_DEPTH);
  localparam int USED_W  = $clog2(POOL_DEPTH + 1);

  localparam int CMD_W  = 2;
  localparam int CHR_W  = 8;
  localparam int AMT_W  = 11;
  localparam int STAT_W = 2;
  localparam int CMP_W  = (VER_W > AMT_W) ? VER_W : AMT_W;

  localparam logic [CMD_W-1:0] CMD_TYPE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNDO = 2'd1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_ARG = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    WALK_TYPE  = 2'd0,
    WALK_QUERY = 2'd1,
    WALK_COUNT = 2'd2
  } walk_op_t;

  typedef struct packed {
    logic [NODE_AW-1:0] left;
    logic [NODE_AW-1:0] right;
    logic [VER_W-1:0]   cnt;
    logic [CHR_W-1:0]   chr;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic               start;
    walk_op_t           op;
    logic [NODE_AW-1:0] root;
    logic [VER_W-1:0]   key;
    logic [CHR_W-1:0]   chr;
    logic [USED_W-1:0]  base;
  } walk_req_t;

  typedef struct packed {
    logic              done;
    logic              full;
    logic [CHR_W-1:0]  chr;
    logic [VER_W-1:0]  cnt;
    logic [USED_W-1:0] next_free;
  } walk_rsp_t;

endpackage

// File: rtl/core/vtb_tree_walk.sv
// node pool memory and the tree walker: path copy, k-th search, root count
// depends on vtb_pkg
module vtb_tree_walk (
  input  logic               clk,
  input  logic               rst,
  input  vtb_pkg::walk_req_t req,
  output vtb_pkg::walk_rsp_t rsp
);
  import vtb_pkg::*;

  typedef enum logic [4:0] {
    W_IDLE  = 5'b00001,
    W_TREAD = 5'b00010,
    W_QNODE = 5'b00100,
    W_QLEFT = 5'b01000,
    W_CNT   = 5'b10000
  } wstate_t;

  wstate_t state;

  logic [NODE_W-1:0]  pool [POOL_DEPTH];
  logic               rd_en;
  logic [NODE_AW-1:0] rd_addr;
  logic [NODE_W-1:0]  rd_data;
  logic               rd_null;
  logic               wr_en;
  logic [NODE_AW-1:0] wr_addr;
  node_t              wr_node;
  node_t              cur;

  logic [VER_W-1:0]   lo;
  logic [VER_W-1:0]   hi;
  logic [VER_W-1:0]   key;
  logic [CHR_W-1:0]   chr;
  logic [USED_W-1:0]  idx;
  logic [NODE_AW-1:0] left_q;
  logic [NODE_AW-1:0] right_q;

  logic [VER_W:0]     mid_sum;
  logic [VER_W-1:0]   mid;
  logic               leaf;
  logic               go_left;
  logic               q_left;
  logic               idx_ok;

  // pool: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) pool[wr_addr] <= wr_node;
    if (rd_en) begin
      rd_data <= pool[rd_addr];
      rd_null <= (rd_addr == '0);
    end
  end

  // node zero is the null node and is never written
  assign cur     = rd_null ? '0 : node_t'(rd_data);
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[VER_W:1];
  assign leaf    = (lo == hi);
  assign go_left = (key <= mid);
  assign q_left  = (cur.cnt >= key);
  assign idx_ok  = (idx < USED_W'(POOL_DEPTH));
  assign wr_addr = idx[NODE_AW-1:0];

  always_comb begin
    wr_node     = cur;
    wr_node.cnt = cur.cnt + 1'b1;
    if (leaf) begin
      wr_node.chr = chr;
    end else if (go_left) begin
      wr_node.left = NODE_AW'(idx + 1'b1);
    end else begin
      wr_node.right = NODE_AW'(idx + 1'b1);
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    unique case (state)
      W_IDLE: begin
        if (req.start) begin
          rd_en   = 1'b1;
          rd_addr = req.root;
        end
      end
      W_TREAD: begin
        wr_en = idx_ok;
        if (idx_ok && !leaf) begin
          rd_en   = 1'b1;
          rd_addr = go_left ? cur.left : cur.right;
        end
      end
      W_QNODE: begin
        if (!leaf) begin
          rd_en   = 1'b1;
          rd_addr = cur.left;
        end
      end
      W_QLEFT: begin
        rd_en   = 1'b1;
        rd_addr = q_left ? left_q : right_q;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= W_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        W_IDLE: begin
          if (req.start) begin
            key      <= req.key;
            chr      <= req.chr;
            idx      <= req.base;
            lo       <= VER_W'(1);
            hi       <= VER_W'(MAX_OPS);
            rsp.full <= 1'b0;
            unique case (req.op)
              WALK_TYPE:  state <= W_TREAD;
              WALK_QUERY: state <= W_QNODE;
              default:    state <= W_CNT;
            endcase
          end
        end
        W_TREAD: begin
          // copy one node of the path per cycle, child pointer to the next copy
          if (!idx_ok) begin
            rsp.full <= 1'b1;
            rsp.done <= 1'b1;
            state    <= W_IDLE;
          end else if (leaf) begin
            rsp.next_free <= idx + 1'b1;
            rsp.done      <= 1'b1;
            state         <= W_IDLE;
          end else begin
            idx <= idx + 1'b1;
            if (go_left) begin
              hi <= mid;
            end else begin
              lo <= mid + 1'b1;
            end
          end
        end
        W_QNODE: begin
          if (leaf) begin
            rsp.chr  <= cur.chr;
            rsp.done <= 1'b1;
            state    <= W_IDLE;
          end else begin
            left_q  <= cur.left;
            right_q <= cur.right;
            state   <= W_QLEFT;
          end
        end
        W_QLEFT: begin
          // cur holds the left child; its count picks the side
          if (q_left) begin
            hi <= mid;
          end else begin
            key <= key - cur.cnt;
            lo  <= mid + 1'b1;
          end
          state <= W_QNODE;
        end
        W_CNT: begin
          rsp.cnt  <= cur.cnt;
          rsp.done <= 1'b1;
          state    <= W_IDLE;
        end
        default: begin
          state <= W_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/versioned_text_buffer_with_undo_unit.sv
// top level of the versioned text buffer with undo: request control,
// version root table and result register; depends on vtb_pkg, vtb_tree_walk
// and versioned_text_buffer_with_undo_unit_macros.svh
//
//   channel    handshake              payload
//   request    req_valid / req_stall  cmd, ch, amount
//   response   rsp_valid / rsp_stall  out_char, status
//
// one request at a time: a new request is taken only after the previous result has moved
// into the output register; the time per request is set by the single read port of the
// node pool, whose read is registered
// rst clears version count, current root and text length, and sets the pool fill count to one;
// both memories need no clearing: entry zero of each reads as the null value
// a finished response waits while the output register is stalled; req_stall low only when idle
`include "versioned_text_buffer_with_undo_unit_macros.svh"

module versioned_text_buffer_with_undo_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [vtb_pkg::CMD_W-1:0]  cmd,
  input  logic [vtb_pkg::CHR_W-1:0]  ch,
  input  logic [vtb_pkg::AMT_W-1:0]  amount,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [vtb_pkg::CHR_W-1:0]  out_char,
  output logic [vtb_pkg::STAT_W-1:0] status
);
  import vtb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_ROOT   = 5'b00100,
    S_WALK   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state;

  // captured request
  logic [CMD_W-1:0]   cmd_q;
  logic [CHR_W-1:0]   ch_q;
  logic [AMT_W-1:0]   amount_q;

  // architectural state kept in flops: current version, its root, text length and pool fill count
  logic [VER_W-1:0]   vnow;
  logic [VER_W-1:0]   cur_len;
  logic [NODE_AW-1:0] cur_root;
  logic [USED_W-1:0]  nodes_used;

  // version root table
  logic [NODE_AW-1:0] roots [MAX_OPS + 1];
  logic               root_rd_en;
  logic [VER_W-1:0]   root_rd_addr;
  logic [NODE_AW-1:0] root_rd_data;
  logic               root_rd_null;
  logic               root_wr_en;
  logic [VER_W-1:0]   root_wr_addr;
  logic [NODE_AW-1:0] root_val;
  logic [NODE_AW-1:0] undo_root;
  logic [NODE_AW-1:0] new_root;

  logic               is_type;
  logic               is_undo;
  logic               is_query;
  logic               ver_full;
  logic               text_full;
  logic               undo_far;
  logic               query_bad;
  logic               dec_err;
  status_t            dec_status;
  logic               commit;
  logic               rsp_free;

  status_t            res_status;
  logic [CHR_W-1:0]   res_char;

  walk_req_t          wreq;
  walk_rsp_t          wrsp;

  vtb_tree_walk u_walk (
    .clk (clk),
    .rst (rst),
    .req (wreq),
    .rsp (wrsp)
  );

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // request decode and range checks
  assign is_type   = (cmd_q == CMD_TYPE);
  assign is_undo   = (cmd_q == CMD_UNDO);
  assign is_query  = !is_type && !is_undo;
  assign ver_full  = (vnow >= VER_W'(MAX_OPS));
  assign text_full = (cur_len >= VER_W'(MAX_OPS));
  assign undo_far  = (CMP_W'(amount_q) > CMP_W'(vnow));
  assign query_bad = (amount_q == '0) || (CMP_W'(amount_q) > CMP_W'(cur_len));

  always_comb begin
    dec_err    = 1'b1;
    dec_status = STAT_OK;
    unique case (cmd_q)
      CMD_TYPE: begin
        if (ver_full || text_full) begin
          dec_status = STAT_FULL;
        end else begin
          dec_err = 1'b0;
        end
      end
      CMD_UNDO: begin
        // a full version table wins over an undo that reaches too far
        priority if (ver_full) begin
          dec_status = STAT_FULL;
        end else if (undo_far) begin
          dec_status = STAT_BAD_ARG;
        end else begin
          dec_err = 1'b0;
        end
      end
      default: begin
        if (query_bad) begin
          dec_status = STAT_BAD_ARG;
        end else begin
          dec_err = 1'b0;
        end
      end
    endcase
  end

  // root table read for undo: entry zero is the empty text
  assign root_rd_en   = (state == S_DECODE) && is_undo && !dec_err;
  assign root_rd_addr = VER_W'(CMP_W'(vnow) - CMP_W'(amount_q));
  assign root_val     = root_rd_null ? '0 : root_rd_data;

  // a type that ran out of pool leaves everything as it was
  assign commit       = (state == S_WALK) && wrsp.done && !is_query
                        && !(is_type && wrsp.full);
  assign new_root     = is_type ? NODE_AW'(nodes_used) : undo_root;
  assign root_wr_en   = commit;
  assign root_wr_addr = vnow + 1'b1;

  always_ff @(posedge clk) begin
    if (root_wr_en) roots[root_wr_addr] <= new_root;
    if (root_rd_en) begin
      root_rd_data <= roots[root_rd_addr];
      root_rd_null <= (root_rd_addr == '0);
    end
  end

  // walker start: type and query leave decode, undo counts the old root
  always_comb begin
    wreq.start = 1'b0;
    wreq.op    = WALK_COUNT;
    wreq.root  = cur_root;
    wreq.key   = cur_len + 1'b1;
    wreq.chr   = ch_q;
    wreq.base  = nodes_used;
    if ((state == S_DECODE) && !dec_err && !is_undo) begin
      wreq.start = 1'b1;
      wreq.op    = is_type ? WALK_TYPE : WALK_QUERY;
      wreq.key   = is_type ? VER_W'(cur_len + 1'b1) : VER_W'(amount_q);
    end else if (state == S_ROOT) begin
      wreq.start = 1'b1;
      wreq.op    = WALK_COUNT;
      wreq.root  = root_val;
    end
  end

  // output register valid: set as a result moves in, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      vnow       <= '0;
      cur_len    <= '0;
      cur_root   <= '0;
      nodes_used <= USED_W'(1);
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_q    <= cmd;
            ch_q     <= ch;
            amount_q <= amount;
            state    <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (dec_err) begin
            res_status <= dec_status;
            res_char   <= '0;
            state      <= S_DONE;
          end else if (is_undo) begin
            state <= S_ROOT;
          end else begin
            state <= S_WALK;
          end
        end
        S_ROOT: begin
          undo_root <= root_val;
          state     <= S_WALK;
        end
        S_WALK: begin
          if (wrsp.done) begin
            res_char   <= is_query ? wrsp.chr : '0;
            res_status <= (is_type && wrsp.full) ? STAT_FULL : STAT_OK;
            if (commit) begin
              vnow     <= vnow + 1'b1;
              cur_root <= new_root;
              cur_len  <= is_type ? VER_W'(cur_len + 1'b1) : wrsp.cnt;
              if (is_type) nodes_used <= wrsp.next_free;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (rsp_free) begin
            out_char <= res_char;
            status   <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `VTB_ASSERT_IMP(a_ver_bound, clk, rst, 1'b1, vnow <= VER_W'(MAX_OPS), "version past table")
  `VTB_ASSERT_IMP(a_len_le_ver, clk, rst, 1'b1, cur_len <= vnow, "text longer than versions")
  `VTB_ASSERT_IMP(a_pool_bound, clk, rst, 1'b1, nodes_used <= USED_W'(POOL_DEPTH), "pool overfill")
  `VTB_ASSERT_NXT(a_pool_grows, clk, rst, commit && is_type, nodes_used > $past(nodes_used), "no node")

endmodule

// File: test/tb.sv
// testbench for versioned_text_buffer_with_undo_unit: typed text, undo and query requests
// are checked against a versioned text predictor; depends on vtb_pkg and the rtl top level
`timescale 1ns / 100ps

module tb;
  import vtb_pkg::*;

  // cmd has no named query code in the package; both remaining codes walk the tree
  localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY_ALT = 2'd3;

  localparam int RANDOM_ITEMS = 1680;
  localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake before giving up
  localparam int SETTLE_TICKS = 40;

  typedef struct {
    logic [CHR_W-1:0] chr;
    status_t          st;
  } edit_result_t;

  // predictor: every version is a pointer into a chain of appended characters,
  // so a version is a text and undo only copies a pointer
  class text_version_scoreboard;
    int unsigned      seg_prev [0:MAX_OPS];
    logic [CHR_W-1:0] seg_chr  [0:MAX_OPS];
    int unsigned      seg_len  [0:MAX_OPS];
    int unsigned      seg_count;
    int unsigned      ver_seg  [0:MAX_OPS];
    int unsigned      ver_now;
    int unsigned      pool_used;
    edit_result_t     due[$];
    int unsigned      mismatches;

    function new();
      seg_prev[0]  = 0;
      seg_chr[0]   = '0;
      seg_len[0]   = 0;
      seg_count    = 1;
      ver_seg[0]   = 0;
      ver_now      = 0;
      pool_used    = 1;  // null node reserved
      mismatches   = 0;
    endfunction

    // tree levels from the root down to leaf pos
    function int unsigned path_depth(int unsigned pos);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned n;
      lo = 1;
      hi = MAX_OPS;
      n  = 1;
      while (lo != hi) begin
        mid = (lo + hi) >> 1;
        if (pos <= mid) hi = mid;
        else lo = mid + 1;
        n++;
      end
      return n;
    endfunction

    function int unsigned text_len();
      return seg_len[ver_seg[ver_now]];
    endfunction

    function int unsigned versions();
      return ver_now;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void note_request(logic [CMD_W-1:0] c, logic [CHR_W-1:0] h,
                               logic [AMT_W-1:0] a);
      edit_result_t r;
      int unsigned  cur;
      int unsigned  len;
      int unsigned  need;
      int unsigned  k;
      int unsigned  t;
      cur   = ver_seg[ver_now];
      len   = seg_len[cur];
      k     = a;
      r.chr = '0;
      r.st  = STAT_OK;
      case (c)
        CMD_TYPE: begin
          if (ver_now >= MAX_OPS || len >= MAX_OPS) begin
            r.st = STAT_FULL;
          end else begin
            need = path_depth(len + 1);
            if (pool_used > POOL_DEPTH || need > POOL_DEPTH - pool_used) begin
              r.st = STAT_FULL;
            end else begin
              seg_prev[seg_count]  = cur;
              seg_chr[seg_count]   = h;
              seg_len[seg_count]   = len + 1;
              ver_seg[ver_now + 1] = seg_count;
              seg_count++;
              pool_used += need;
              ver_now++;
            end
          end
        end
        CMD_UNDO: begin
          // table full is checked ahead of the step count
          if (ver_now >= MAX_OPS) r.st = STAT_FULL;
          else if (k > ver_now) r.st = STAT_BAD_ARG;
          else begin
            ver_seg[ver_now + 1] = ver_seg[ver_now - k];
            ver_now++;
          end
        end
        default: begin
          if (k == 0 || k > len) begin
            r.st = STAT_BAD_ARG;
          end else begin
            t = cur;
            repeat (len - k) t = seg_prev[t];
            r.chr = seg_chr[t];
          end
        end
      endcase
      due.push_back(r);
    endfunction

    task check_response(logic [CHR_W-1:0] oc, logic [STAT_W-1:0] st);
      edit_result_t e;
      if (due.size() == 0) begin
        report_mismatch($sformatf("response char %0h status %0d with nothing outstanding",
                                  oc, st));
        return;
      end
      e = due.pop_front();
      if (oc !== e.chr)
        report_mismatch($sformatf("out_char %0h, expected %0h", oc, e.chr));
      if (st !== e.st)
        report_mismatch($sformatf("status %0d, expected %0d", st, e.st));
    endtask
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  logic [CMD_W-1:0] cmd       = CMD_QUERY;
  logic [CHR_W-1:0] ch        = '0;
  logic [AMT_W-1:0] amount    = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  logic [CHR_W-1:0] out_char;
  logic [STAT_W-1:0] status;

  int unsigned send_idle_pct = 12;
  int unsigned rsp_stall_pct = 54;
  int unsigned quiet         = 0;

  text_version_scoreboard edits = new();

  versioned_text_buffer_with_undo_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .ch        (ch),
    .amount    (amount),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .out_char  (out_char),
    .status    (status)
  );

  always #10 clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  // response side: values read here are the ones present at the edge
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      edits.check_response(out_char, status);
  end

  // watchdog: any handshake restarts the count
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("** versioned_text_buffer_with_undo_unit: FAILED **");
        $finish;
      end
    end
  end

  // present one request, holding it until accepted; the predictor is updated
  // here rather than in a monitor so the next pick sees the new state
  task automatic send_request(input logic [CMD_W-1:0] c, input logic [CHR_W-1:0] h,
                              input logic [AMT_W-1:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd       <= c;
    ch        <= h;
    amount    <= a;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    edits.note_request(c, h, a);
  endtask

  // drop valid and wait for every outstanding response
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (edits.pending() != 0);
  endtask

  // mostly well-formed edits: typing grows the text, small undos, queries
  // inside the text; the rest are out-of-range steps and positions.
  // the type/undo share fills the version table shortly before the end, so the
  // table-full rejections get exercised; pool-full and text-full cannot occur
  // at these sizes since the version table always runs out first
  task automatic random_request();
    int unsigned      pick;
    int unsigned      vers;
    int unsigned      len;
    logic [CMD_W-1:0] c;
    logic [AMT_W-1:0] a;
    vers = edits.versions();
    len  = edits.text_len();
    pick = $urandom_range(99);
    a    = AMT_W'($urandom_range(2047));
    if (pick < 50) begin
      c = CMD_TYPE;
    end else if (pick < 65) begin
      c    = CMD_UNDO;
      pick = $urandom_range(9);
      if (pick < 7) a = AMT_W'($urandom_range((vers < 8) ? vers : 8, 0));
      else if (pick < 9) a = AMT_W'($urandom_range(vers, 0));
    end else begin
      c    = ($urandom_range(9) == 0) ? CMD_QUERY_ALT : CMD_QUERY;
      pick = $urandom_range(9);
      if (pick < 8 && len != 0) a = AMT_W'($urandom_range(len, 1));
      else if (pick == 8) a = $urandom_range(1) ? AMT_W'(len + 1) : '0;
    end
    send_request(c, CHR_W'($urandom_range(255)), a);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty text, undo bounds, both extremes of a character,
    // queries through both query codes and past the end
    send_request(CMD_QUERY,     8'h00, 11'd0);     // position zero
    send_request(CMD_QUERY_ALT, 8'h00, 11'd1);     // nothing typed yet
    send_request(CMD_UNDO,      8'h00, 11'd1);     // further back than version zero
    send_request(CMD_UNDO,      8'h00, 11'd0);     // undo by zero copies the current text
    send_request(CMD_TYPE,      8'h00, 11'd0);
    send_request(CMD_TYPE,      8'hff, 11'd2047);
    send_request(CMD_TYPE,      8'ha5, 11'd0);
    send_request(CMD_TYPE,      8'h5a, 11'd0);
    send_request(CMD_QUERY,     8'h00, 11'd1);
    send_request(CMD_QUERY_ALT, 8'h00, 11'd2);
    send_request(CMD_QUERY,     8'h00, 11'd3);
    send_request(CMD_QUERY_ALT, 8'h00, 11'd4);
    send_request(CMD_QUERY,     8'h00, 11'd5);     // one past the end
    send_request(CMD_QUERY,     8'h00, 11'd2047);
    send_request(CMD_UNDO,      8'h00, 11'd2);     // back to two characters
    send_request(CMD_QUERY,     8'h00, 11'd2);
    send_request(CMD_QUERY,     8'h00, 11'd3);
    send_request(CMD_UNDO,      8'h00, 11'd2047);
    send_request(CMD_UNDO,      8'h00, 11'd1024);
    send_request(CMD_UNDO,      8'h00, 11'd0);
    send_request(CMD_TYPE,      8'h80, 11'd0);
    send_request(CMD_QUERY,     8'h00, 11'd3);

    // random: three idling phases, with one full drain in the middle
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 54;
        rsp_stall_pct = 12;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        rsp_stall_pct = 0;
      end
      if (i == RANDOM_ITEMS / 2) drain();
      random_request();
    end

    drain();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (edits.mismatches == 0) begin
      $display("** versioned_text_buffer_with_undo_unit: PASSED **");
    end else begin
      $display("** versioned_text_buffer_with_undo_unit: FAILED **");
    end
    $finish;
  end

endmodule
